// ===== hw/rtl/odavg_pkg.sv =====
package odavg_pkg;

  localparam int DATA_W             = 16;
  localparam int CHIDX_W            = 4;
  localparam int CHANS_CFG_W        = 5;
  localparam int FAC_CFG_W          = 7;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int MAX_CHANNELS_DEF   = 16;
  localparam int MAX_DECIMATION_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE = 2'd2;

  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_PEND   = 2'd1,
    SRC_DIV    = 2'd2
  } out_src_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     load_out;
    out_src_t out_src;
  } cmd_t;

  typedef struct packed {
    logic pass;
    logic div_need;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/multichannel_offset_decimating_averager_unit.sv =====
// Channel   Direction  Beat contents
// s_*       in         tdata[15:0] raw_sample
// m_*       out        tdata[15:0] averaged_sample, tuser[3:0] channel_index
// cfg_*     in         cfg_index selects channels_in_scan, decimation_factor, zero_code
//
// Accumulating beats, and pass-through beats while the output is free, are taken without leaving the idle state.
// The last scan of a group is accepted, then divided in the restoring divider, which
// works through the sum bit by bit, and the quotient is then loaded into the output
// register once the output is free.
// Reset is synchronous and clears the configuration registers, accumulators, scan positions and output valid.
// A stalled output does not stop accumulating beats; a beat that makes a result is
// still taken and waits in a holding register or the divider, and further input
// waits until that result moves into the output register.
module multichannel_offset_decimating_averager_unit
  import odavg_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int MAX_DECIMATION = MAX_DECIMATION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // raw_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // averaged_sample
  output logic [CHIDX_W-1:0]    m_tuser    // channel_index
);

  cmd_t    cmd;
  status_t status;

  odavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  odavg_datapath #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_DECIMATION (MAX_DECIMATION)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .raw_sample      (s_tdata),
    .cmd             (cmd),
    .status          (status),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .averaged_sample (m_tdata),
    .channel_index   (m_tuser)
  );

endmodule

// ===== hw/rtl/odavg_div.sv =====
module odavg_div
  import odavg_pkg::*;
#(
  parameter int SUM_W = 22,
  parameter int FAC_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FAC_W-1:0]  divisor,
  input  logic              neg,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [FAC_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [FAC_W-1:0]  dvs;
  logic              neg_q;
  logic [FAC_W:0]    trial;
  logic              fits;
  logic [DATA_W-1:0] q_lo;

  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign q_lo  = quo[DATA_W-1:0];
  assign quotient = neg_q ? ((~q_lo) + DATA_W'(1)) : q_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      dvs   <= divisor;
      neg_q <= neg;
    end else if (busy) begin
      if (fits) begin
        rem <= FAC_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[FAC_W-1:0];
      end
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/odavg_datapath.sv =====
module odavg_datapath
  import odavg_pkg::*;
#(
  parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
  parameter int MAX_DECIMATION = MAX_DECIMATION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [DATA_W-1:0]     raw_sample,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [DATA_W-1:0]     averaged_sample,
  output logic [CHIDX_W-1:0]    channel_index
);

  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int SCAN_W   = $clog2(MAX_DECIMATION);
  localparam int FAC_W    = $clog2(MAX_DECIMATION + 1);
  localparam int SUM_W    = DATA_W + SCAN_W;

  logic [CHANS_CFG_W-1:0] chans;
  logic [FAC_CFG_W-1:0]   fac_cfg;
  logic [DATA_W-1:0]      zero_code;

  logic signed [SUM_W-1:0] sums [MAX_CHANNELS];
  logic [CH_W-1:0]         ch_pos;
  logic [SCAN_W-1:0]       scan_pos;

  logic [DATA_W-1:0]  pend_word;
  logic [CH_W-1:0]    pend_ch;

  logic [CH_CNT_W-1:0]     eff_ch;
  logic [FAC_W-1:0]        eff_fac;
  logic [CH_W-1:0]         ch;
  logic [DATA_W-1:0]       word;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag;
  logic                    pass;
  logic                    last_scan;
  logic                    last_ch;
  logic                    clear;
  logic                    div_busy;
  logic [DATA_W-1:0]       quotient;

  always_comb begin
    if (chans == '0) begin
      eff_ch = CH_CNT_W'(1);
    end else if (int'(chans) > MAX_CHANNELS) begin
      eff_ch = CH_CNT_W'(MAX_CHANNELS);
    end else begin
      eff_ch = CH_CNT_W'(chans);
    end
    if (fac_cfg == '0) begin
      eff_fac = FAC_W'(1);
    end else if (int'(fac_cfg) > MAX_DECIMATION) begin
      eff_fac = FAC_W'(MAX_DECIMATION);
    end else begin
      eff_fac = FAC_W'(fac_cfg);
    end
  end

  assign ch        = (CH_CNT_W'(ch_pos) >= eff_ch) ? '0 : ch_pos;
  assign word      = raw_sample - zero_code;
  assign sum       = sums[ch] + {{SCAN_W{word[DATA_W-1]}}, word};
  assign mag       = sum[SUM_W-1] ? ((~sum) + SUM_W'(1)) : sum;
  assign pass      = eff_fac == FAC_W'(1);
  assign last_scan = (FAC_W'(scan_pos) + FAC_W'(1)) >= eff_fac;
  assign last_ch   = (CH_CNT_W'(ch) + CH_CNT_W'(1)) >= eff_ch;
  assign clear     = cfg_we && (cfg_index == REG_CHANNELS || cfg_index == REG_FACTOR);

  assign status.pass     = pass;
  assign status.div_need = !pass && last_scan;
  assign status.div_done = !div_busy;
  assign status.out_free = !m_tvalid || m_tready;

  odavg_div #(
    .SUM_W(SUM_W),
    .FAC_W(FAC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (eff_fac),
    .neg      (sum[SUM_W-1]),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chans     <= CHANS_CFG_W'(1);
      fac_cfg   <= FAC_CFG_W'(1);
      zero_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNELS:  chans     <= cfg_data[CHANS_CFG_W-1:0];
        REG_FACTOR:    fac_cfg   <= cfg_data[FAC_CFG_W-1:0];
        REG_ZERO_CODE: zero_code <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums[i] <= '0;
      end
      ch_pos   <= '0;
      scan_pos <= '0;
    end else if (cmd.accept) begin
      if (!pass) begin
        sums[ch] <= last_scan ? '0 : sum;
      end
      if (last_ch) begin
        ch_pos <= '0;
        if (pass || last_scan) begin
          scan_pos <= '0;
        end else begin
          scan_pos <= scan_pos + SCAN_W'(1);
        end
      end else begin
        ch_pos <= ch + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_word <= word;
      pend_ch   <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.out_src)
        SRC_DIRECT: begin
          averaged_sample <= word;
          channel_index   <= CHIDX_W'(ch);
        end
        SRC_PEND: begin
          averaged_sample <= pend_word;
          channel_index   <= CHIDX_W'(pend_ch);
        end
        SRC_DIV: begin
          averaged_sample <= quotient;
          channel_index   <= CHIDX_W'(pend_ch);
        end
        default: begin
          averaged_sample <= word;
          channel_index   <= CHIDX_W'(ch);
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/odavg_ctrl.sv =====
module odavg_ctrl
  import odavg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    PUSH = 3'b010,
    DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.out_src   = SRC_DIRECT;
    unique case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.pass) begin
            if (status.out_free) begin
              cmd.load_out = 1'b1;
            end else begin
              state_next = PUSH;
            end
          end else if (status.div_need) begin
            cmd.div_start = 1'b1;
            state_next    = DIV;
          end
        end
      end
      PUSH: begin
        cmd.out_src = SRC_PEND;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      DIV: begin
        cmd.out_src = SRC_DIV;
        if (status.div_done && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
